### design/assert_macros.svh
// Assertion macros used by the accumulator RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ICA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define ICA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ICA_ASSERT(lbl, prop, msg)
`define ICA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/ica_pkg.sv
// Shared types, constants and cost functions of the instruction current accumulator.
// No dependencies.
package ica_pkg;

    localparam int SLOT_COUNT_DEF = 1024;
    localparam int TYPE_COUNT_DEF = 64;

    localparam int TICK_W   = 32;
    localparam int ADDR_W   = 32;
    localparam int CHARGE_W = 64;
    localparam int CYCLE_W  = 32;
    localparam int USAGE_W  = 32;
    localparam int SLOTNUM_W = 10;
    localparam int QUERY_W  = 10;
    localparam int TYPE_W   = 6;
    localparam int CYC_IN_W = 4;
    localparam int META_W   = 16;
    localparam int CUR_W    = 13;
    localparam int FLASH_W  = 11;
    localparam int ADD_W    = 17;

    localparam logic [31:0] SLOT_LENGTH_RST = 32'd1000;

    localparam logic [TYPE_W-1:0] T_STR    = 6'd0;
    localparam logic [TYPE_W-1:0] T_LDR    = 6'd1;
    localparam logic [TYPE_W-1:0] T_PUSH   = 6'd18;
    localparam logic [TYPE_W-1:0] T_STMIA  = 6'd19;
    localparam logic [TYPE_W-1:0] T_LDMIA  = 6'd20;
    localparam logic [TYPE_W-1:0] T_POP    = 6'd21;
    localparam logic [TYPE_W-1:0] T_BNE    = 6'd23;
    localparam logic [TYPE_W-1:0] T_BEQ    = 6'd24;
    localparam logic [TYPE_W-1:0] T_BRANCH = 6'd26;

    localparam logic [ADD_W-1:0] NOT_TAKEN_BNE   = 17'd5200;
    localparam logic [ADD_W-1:0] NOT_TAKEN_OTHER = 17'd3920;
    localparam logic [ADD_W-1:0] TAKEN_CYCLES    = 17'd3;

    localparam logic [ADDR_W-1:0] RAM_BASE    = 32'h2000_0000;
    localparam logic [ADDR_W-1:0] PERIPH_BASE = 32'h4000_0000;
    localparam logic [3:0] REG_FLASH = 4'hf;
    localparam logic [3:0] REG_RAM   = 4'he;

    localparam logic [CUR_W-1:0] CUR_PERIPH  = 13'd3000;
    localparam logic [CUR_W-1:0] CUR_DEFAULT = 13'd4000;
    localparam logic [CUR_W-1:0] CUR_LD_FLASH = 13'd5760;
    localparam logic [CUR_W-1:0] CUR_LD_RAM  = 13'd3520;
    localparam logic [CUR_W-1:0] CUR_ST      = 13'd4133;
    localparam logic [CUR_W:0] STEP_BIAS  = 14'd480;
    localparam logic [CUR_W:0] STEP_UNIT  = 14'd240;

    typedef enum logic [1:0] {
        OP_CHARGE     = 2'd0,
        OP_READ_SLOT  = 2'd1,
        OP_READ_USAGE = 2'd2,
        OP_NONE       = 2'd3
    } ica_op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PEND_RD,
        S_PEND_WR,
        S_SLOT_RD,
        S_SLOT_UPD,
        S_Q_RD,
        S_Q_TAKE,
        S_DONE
    } ica_state_t;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic div_step;
        logic usage_rd;
        logic q_rd;
        logic q_take;
        logic pend_rd;
        logic pend_wr;
        logic slot_rd;
        logic slot_wr;
        logic out_load;
    } ica_cmd_t;

    typedef struct packed {
        logic    clr_last;
        logic    div_last;
        logic    pend_go;
        ica_op_t in_op;
    } ica_sts_t;

    function automatic logic [FLASH_W-1:0] flash_cost(input logic [ADDR_W-1:0] d);
        logic [FLASH_W-1:0] c;
        if (|d[31:12])
            c = 11'd1067;
        else if (|d[11:10])
            c = 11'd967;
        else if (|d[9:8])
            c = 11'd867;
        else if (|d[7:6])
            c = 11'd233;
        else if (|d[5:4])
            c = 11'd67;
        else
            c = 11'd0;
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] access_addr(
        input logic [META_W-1:0] meta,
        input logic [ADDR_W-1:0] base,
        input logic [ADDR_W-1:0] idx
    );
        logic [ADDR_W-1:0] a;
        if (meta[14:11] == REG_FLASH)
            a = RAM_BASE - 32'd1;
        else if (meta[14:11] == REG_RAM)
            a = RAM_BASE;
        else if (meta[15])
            a = base + idx;
        else
            a = base + {21'd0, meta[10:0]};
        return a;
    endfunction

    function automatic logic [CUR_W-1:0] type_current(input logic [TYPE_W-1:0] t);
        logic [CUR_W-1:0] c;
        case (t)
            6'd2:    c = 13'd4520;
            6'd3:    c = 13'd3827;
            6'd4:    c = 13'd3840;
            6'd5:    c = 13'd3933;
            6'd6:    c = 13'd3760;
            6'd7:    c = 13'd3867;
            6'd8:    c = 13'd3760;
            6'd9:    c = 13'd3760;
            6'd10:   c = 13'd3760;
            6'd11:   c = 13'd3707;
            6'd12:   c = 13'd3707;
            6'd13:   c = 13'd3707;
            6'd14:   c = 13'd3693;
            6'd15:   c = 13'd3693;
            6'd16:   c = 13'd3693;
            6'd17:   c = 13'd3826;
            6'd22:   c = 13'd4000;
            6'd23:   c = 13'd4867;
            6'd24:   c = 13'd4947;
            6'd25:   c = 13'd4773;
            6'd26:   c = 13'd4933;
            6'd27:   c = 13'd4933;
            6'd28:   c = 13'd4000;
            6'd29:   c = 13'd4000;
            6'd30:   c = 13'd3867;
            6'd31:   c = 13'd4000;
            6'd0, 6'd1, 6'd18, 6'd19, 6'd20, 6'd21: c = 13'd0;
            default: c = CUR_DEFAULT;
        endcase
        return c;
    endfunction

    // Multi-register transfers lose 240 per cycle beyond two.
    function automatic logic [CUR_W-1:0] cost_current(
        input logic [TYPE_W-1:0]   t,
        input logic [CYC_IN_W-1:0] cyc,
        input logic [ADDR_W-1:0]   a
    );
        logic [CUR_W:0]   sub;
        logic [CUR_W-1:0] c;
        sub = (CUR_W+1)'(cyc) * STEP_UNIT;
        if (t == T_LDR) begin
            if (a < RAM_BASE)
                c = CUR_LD_FLASH;
            else if (a < PERIPH_BASE)
                c = CUR_LD_RAM;
            else
                c = CUR_PERIPH;
        end else if (t == T_STR) begin
            c = (a >= PERIPH_BASE) ? CUR_PERIPH : CUR_ST;
        end else if (t == T_PUSH || t == T_STMIA) begin
            c = CUR_W'({1'b0, CUR_ST} + STEP_BIAS - sub);
        end else if (t == T_LDMIA) begin
            c = CUR_W'({1'b0, CUR_LD_FLASH} + STEP_BIAS - sub);
        end else if (t == T_POP) begin
            c = CUR_W'({1'b0, CUR_LD_RAM} + STEP_BIAS - sub);
        end else begin
            c = type_current(t);
        end
        return c;
    endfunction

endpackage

### design/ica_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ica_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/ica_ctrl.sv
// Sequencer of the instruction current accumulator: handshakes and datapath commands.
// Depends on ica_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ica_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  ica_pkg::ica_sts_t sts,
    output ica_pkg::ica_cmd_t cmd
);
    import ica_pkg::*;

    ica_state_t state_reg;
    ica_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (sts.in_op)
                        OP_CHARGE:     state_next = S_DIV;
                        OP_READ_SLOT:  state_next = S_Q_RD;
                        OP_READ_USAGE: state_next = S_Q_RD;
                        default:       state_next = S_DONE;
                    endcase
                end
            end
            S_DIV:
            begin
                if (sts.div_last)
                    state_next = S_PEND_RD;
            end
            S_PEND_RD:  state_next = sts.pend_go ? S_PEND_WR : S_SLOT_RD;
            S_PEND_WR:  state_next = S_SLOT_RD;
            S_SLOT_RD:  state_next = S_SLOT_UPD;
            S_SLOT_UPD: state_next = S_DONE;
            S_Q_RD:     state_next = S_Q_TAKE;
            S_Q_TAKE:   state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_CLEAR:    cmd.clr_step = 1'b1;
            S_IDLE:     cmd.capture  = in_valid;
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.usage_rd = 1'b1;
            end
            S_PEND_RD:  cmd.pend_rd  = sts.pend_go;
            S_PEND_WR:  cmd.pend_wr  = 1'b1;
            S_SLOT_RD:  cmd.slot_rd  = 1'b1;
            S_SLOT_UPD: cmd.slot_wr  = 1'b1;
            S_Q_RD:     cmd.q_rd     = 1'b1;
            S_Q_TAKE:   cmd.q_take   = 1'b1;
            S_DONE:     cmd.out_load = !out_valid_reg || !out_stall;
            default:    cmd = '0;
        endcase
    end

    // Hold the result until transferred; a new one may replace it in the same cycle.
    assign out_valid_next = cmd.out_load | (out_valid_reg & out_stall);
    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;

    `ICA_ASSERT(a_pend_wr_after_rd, cmd.pend_wr |-> $past(cmd.pend_rd), "pending write without read")
    `ICA_ASSERT(a_slot_wr_after_rd, cmd.slot_wr |-> $past(cmd.slot_rd), "slot update without read")
    `ICA_ASSERT(a_load_when_free, cmd.out_load |-> (!out_valid_reg || !out_stall), "result overwritten")
    `ICA_ASSERT_NEXT(a_load_sets_valid, cmd.out_load, out_valid, "loaded result not shown")

endmodule

### design/ica_dp.sv
// Datapath of the instruction current accumulator: divider, cost logic, stores, results.
// Depends on ica_pkg and ica_ram.
module ica_dp #(
    parameter int SLOT_COUNT = ica_pkg::SLOT_COUNT_DEF,
    parameter int TYPE_COUNT = ica_pkg::TYPE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [31:0]                     cfg_wr_data,
    input  logic [1:0]                      opcode,
    input  logic [ica_pkg::TICK_W-1:0]      tick,
    input  logic [ica_pkg::ADDR_W-1:0]      fetch_address,
    input  logic [ica_pkg::TYPE_W-1:0]      instr_type,
    input  logic [ica_pkg::CYC_IN_W-1:0]    cycles,
    input  logic [ica_pkg::META_W-1:0]      access_meta,
    input  logic [ica_pkg::ADDR_W-1:0]      base_reg_value,
    input  logic [ica_pkg::ADDR_W-1:0]      index_reg_value,
    input  logic [ica_pkg::QUERY_W-1:0]     query_index,
    input  ica_pkg::ica_cmd_t               cmd,
    output ica_pkg::ica_sts_t               sts,
    output logic [ica_pkg::SLOTNUM_W-1:0]   slot_number,
    output logic [ica_pkg::CHARGE_W-1:0]    slot_charge_total,
    output logic [ica_pkg::CYCLE_W-1:0]     slot_cycle_total,
    output logic [ica_pkg::USAGE_W-1:0]     usage_count,
    output logic                            slot_overflow
);
    import ica_pkg::*;

    localparam int SIDX_W    = $clog2(SLOT_COUNT);
    localparam int TIDX_W    = $clog2(TYPE_COUNT);
    localparam int CLR_DEPTH = (SLOT_COUNT > TYPE_COUNT) ? SLOT_COUNT : TYPE_COUNT;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int DIV_CNT_W = $clog2(TICK_W);
    localparam int SDATA_W   = CHARGE_W + CYCLE_W;

    // configuration and captured item
    logic [31:0]          slot_length_reg;
    ica_op_t              in_op_reg;
    logic [ADDR_W-1:0]    in_addr_reg;
    logic [TYPE_W-1:0]    in_type_reg;
    logic [CYC_IN_W-1:0]  in_cyc_reg;
    logic [META_W-1:0]    in_meta_reg;
    logic [ADDR_W-1:0]    in_base_reg;
    logic [ADDR_W-1:0]    in_index_reg;
    logic [QUERY_W-1:0]   in_query_reg;

    // divider
    logic [TICK_W-1:0]    div_rem_reg;
    logic [TICK_W-1:0]    div_quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [TICK_W-1:0]    div_len;
    logic [TICK_W:0]      div_shift;
    logic [TICK_W:0]      div_diff;
    logic                 div_ge;

    // cost pipeline
    logic [CUR_W-1:0]     cur_reg;
    logic [FLASH_W-1:0]   flash_reg;
    logic                 nt_hit_reg;
    logic [ADD_W-1:0]     charge_reg;
    logic [ADD_W-1:0]     taken_next;
    logic [ADD_W-1:0]     nt_next;
    logic [ADD_W-1:0]     taken_next_reg;
    logic [ADD_W-1:0]     nt_next_reg;
    logic                 is_branch;

    // deferred branch state
    logic                 pend_flag_reg;
    logic                 pend_valid_reg;
    logic [SIDX_W-1:0]    pend_slot_reg;
    logic [ADD_W-1:0]     taken_reg;
    logic [ADD_W-1:0]     nt_charge_reg;
    logic [CYC_IN_W-1:0]  nt_cyc_reg;
    logic [ADDR_W-1:0]    prev_addr_reg;

    logic [CLR_W-1:0]     clr_cnt_reg;

    logic                 slot_ok;
    logic                 type_ok;
    logic [SIDX_W-1:0]    new_slot;

    // stores
    logic                 s_we;
    logic [SIDX_W-1:0]    s_waddr;
    logic [SDATA_W-1:0]   s_wdata;
    logic                 s_re;
    logic [SIDX_W-1:0]    s_raddr;
    logic [SDATA_W-1:0]   s_rdata;
    logic [CHARGE_W-1:0]  rd_charge;
    logic [CYCLE_W-1:0]   rd_cycle;
    logic [CHARGE_W-1:0]  pend_charge_sum;
    logic [CYCLE_W-1:0]   pend_cycle_sum;
    logic [CHARGE_W-1:0]  slot_charge_sum;
    logic [CYCLE_W-1:0]   slot_cycle_sum;
    logic                 u_we;
    logic [TIDX_W-1:0]    u_waddr;
    logic [USAGE_W-1:0]   u_wdata;
    logic                 u_re;
    logic [TIDX_W-1:0]    u_raddr;
    logic [USAGE_W-1:0]   u_rdata;

    // result and output registers
    logic [SLOTNUM_W-1:0] res_slot_reg;
    logic [CHARGE_W-1:0]  res_charge_reg;
    logic [CYCLE_W-1:0]   res_cycle_reg;
    logic [USAGE_W-1:0]   res_usage_reg;
    logic                 res_ovf_reg;
    logic [SLOTNUM_W-1:0] slot_number_reg;
    logic [CHARGE_W-1:0]  slot_charge_total_reg;
    logic [CYCLE_W-1:0]   slot_cycle_total_reg;
    logic [USAGE_W-1:0]   usage_count_reg;
    logic                 slot_overflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_length_reg <= SLOT_LENGTH_RST;
        else if (cfg_wr_en)
            slot_length_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_op_reg    <= ica_op_t'(opcode);
            in_addr_reg  <= fetch_address;
            in_type_reg  <= instr_type;
            in_cyc_reg   <= cycles;
            in_meta_reg  <= access_meta;
            in_base_reg  <= base_reg_value;
            in_index_reg <= index_reg_value;
            in_query_reg <= query_index;
        end
    end

    // Restoring division, one quotient bit per cycle; a zero length counts as one.
    assign div_len   = (slot_length_reg == '0) ? TICK_W'(1) : slot_length_reg;
    assign div_shift = {div_rem_reg, div_quo_reg[TICK_W-1]};
    assign div_diff  = div_shift - {1'b0, div_len};
    assign div_ge    = !div_diff[TICK_W];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= tick;
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_ge ? div_diff[TICK_W-1:0] : div_shift[TICK_W-1:0];
            div_quo_reg <= {div_quo_reg[TICK_W-2:0], div_ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.capture)
            div_cnt_reg <= '0;
        else if (cmd.div_step)
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
    end

    assign slot_ok  = (div_quo_reg < TICK_W'(SLOT_COUNT));
    assign new_slot = div_quo_reg[SIDX_W-1:0];
    assign type_ok  = (32'(in_type_reg) < 32'(TYPE_COUNT));
    assign is_branch = (in_type_reg == T_BNE) || (in_type_reg == T_BEQ)
                    || (in_type_reg == T_BRANCH);

    // Cost terms settle from the captured item while the divider runs.
    assign taken_next = ADD_W'(cur_reg) * TAKEN_CYCLES + ADD_W'(flash_reg);
    assign nt_next    = ADD_W'(in_cyc_reg)
                      * ((in_type_reg == T_BNE) ? NOT_TAKEN_BNE : NOT_TAKEN_OTHER)
                      + ADD_W'(flash_reg);

    always_ff @(posedge clk)
    begin
        cur_reg        <= cost_current(in_type_reg, in_cyc_reg,
                                       access_addr(in_meta_reg, in_base_reg, in_index_reg));
        flash_reg      <= flash_cost(prev_addr_reg ^ in_addr_reg);
        nt_hit_reg     <= ((in_addr_reg - prev_addr_reg) == 32'd2);
        charge_reg     <= ADD_W'(in_cyc_reg) * ADD_W'(cur_reg) + ADD_W'(flash_reg);
        taken_next_reg <= taken_next;
        nt_next_reg    <= nt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_flag_reg  <= 1'b0;
            pend_valid_reg <= 1'b1;
            pend_slot_reg  <= '0;
            taken_reg      <= '0;
            nt_charge_reg  <= '0;
            nt_cyc_reg     <= '0;
            prev_addr_reg  <= '0;
        end
        else if (cmd.slot_wr)
        begin
            pend_flag_reg  <= is_branch;
            pend_valid_reg <= slot_ok;
            pend_slot_reg  <= slot_ok ? new_slot : '0;
            prev_addr_reg  <= in_addr_reg;
            if (is_branch)
            begin
                taken_reg     <= taken_next_reg;
                nt_charge_reg <= nt_next_reg;
                nt_cyc_reg    <= in_cyc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clr_step)
            clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
    end

    assign rd_charge = s_rdata[SDATA_W-1:CYCLE_W];
    assign rd_cycle  = s_rdata[CYCLE_W-1:0];

    // Resolve the deferred branch: fall-through to the next halfword means not taken.
    assign pend_charge_sum = rd_charge + CHARGE_W'(nt_hit_reg ? nt_charge_reg : taken_reg);
    assign pend_cycle_sum  = rd_cycle
                           + (nt_hit_reg ? CYCLE_W'(nt_cyc_reg) : CYCLE_W'(TAKEN_CYCLES));
    assign slot_charge_sum = rd_charge + CHARGE_W'(charge_reg);
    assign slot_cycle_sum  = rd_cycle + CYCLE_W'(in_cyc_reg);

    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = new_slot;
        s_wdata = {slot_charge_sum, slot_cycle_sum};
        if (cmd.clr_step)
        begin
            s_we    = (32'(clr_cnt_reg) < 32'(SLOT_COUNT));
            s_waddr = SIDX_W'(clr_cnt_reg);
            s_wdata = '0;
        end
        else if (cmd.pend_wr)
        begin
            s_we    = 1'b1;
            s_waddr = pend_slot_reg;
            s_wdata = {pend_charge_sum, pend_cycle_sum};
        end
        else if (cmd.slot_wr)
        begin
            s_we    = slot_ok && !is_branch;
        end
    end

    assign s_re    = cmd.q_rd | cmd.pend_rd | cmd.slot_rd;
    assign s_raddr = cmd.q_rd ? SIDX_W'(in_query_reg)
                   : (cmd.pend_rd ? pend_slot_reg : new_slot);

    always_comb
    begin
        u_we    = 1'b0;
        u_waddr = TIDX_W'(in_type_reg);
        u_wdata = u_rdata + USAGE_W'(1);
        if (cmd.clr_step)
        begin
            u_we    = (32'(clr_cnt_reg) < 32'(TYPE_COUNT));
            u_waddr = TIDX_W'(clr_cnt_reg);
            u_wdata = '0;
        end
        else if (cmd.slot_wr)
        begin
            u_we    = type_ok;
        end
    end

    assign u_re    = cmd.q_rd | cmd.usage_rd;
    assign u_raddr = cmd.q_rd ? TIDX_W'(in_query_reg) : TIDX_W'(in_type_reg);

    ica_ram #(
        .WIDTH (SDATA_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    ica_ram #(
        .WIDTH (USAGE_W),
        .DEPTH (TYPE_COUNT)
    ) u_usage_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .re    (u_re),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_slot_reg   <= '0;
            res_charge_reg <= '0;
            res_cycle_reg  <= '0;
            res_usage_reg  <= '0;
            res_ovf_reg    <= 1'b0;
        end
        else if (cmd.q_take)
        begin
            if (in_op_reg == OP_READ_SLOT)
            begin
                if (32'(in_query_reg) < 32'(SLOT_COUNT))
                begin
                    res_slot_reg   <= in_query_reg;
                    res_charge_reg <= rd_charge;
                    res_cycle_reg  <= rd_cycle;
                end
                else
                begin
                    res_ovf_reg    <= 1'b1;
                end
            end
            else if (in_op_reg == OP_READ_USAGE)
            begin
                if (32'(in_query_reg) < 32'(TYPE_COUNT))
                    res_usage_reg <= u_rdata;
            end
        end
        else if (cmd.slot_wr)
        begin
            if (slot_ok)
            begin
                res_slot_reg   <= SLOTNUM_W'(new_slot);
                res_charge_reg <= is_branch ? rd_charge : slot_charge_sum;
                res_cycle_reg  <= is_branch ? rd_cycle : slot_cycle_sum;
            end
            else
            begin
                res_ovf_reg    <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            slot_number_reg       <= res_slot_reg;
            slot_charge_total_reg <= res_charge_reg;
            slot_cycle_total_reg  <= res_cycle_reg;
            usage_count_reg       <= res_usage_reg;
            slot_overflow_reg     <= res_ovf_reg;
        end
    end

    assign slot_number       = slot_number_reg;
    assign slot_charge_total = slot_charge_total_reg;
    assign slot_cycle_total  = slot_cycle_total_reg;
    assign usage_count       = usage_count_reg;
    assign slot_overflow     = slot_overflow_reg;

    assign sts.clr_last = (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1));
    assign sts.div_last = (div_cnt_reg == DIV_CNT_W'(TICK_W - 1));
    assign sts.pend_go  = pend_flag_reg & pend_valid_reg;
    assign sts.in_op    = ica_op_t'(opcode);

endmodule

### design/instruction_current_accumulator.sv
// Instruction current accumulator: one result for every item. A charge item (opcode 0)
// passes from transfer in to result valid through bit-serial division of tick by
// slot_length, a check for a pending branch, a read and an update on the slot store,
// and the load of the output register. When a deferred branch resolves, its charge is
// written back in an extra step before the slot read. Slot and usage reads pass through
// a store read, a result capture and the output load; opcode 3 goes straight to the
// output load. A new item is taken once the result is loaded, so a result held by
// out_stall delays the next item. After reset a clearing pass over max(SLOT_COUNT,
// TYPE_COUNT) addresses (1024 by default) zeroes the stores before the first item is taken.
// A finished result waits in an output register while the next item is transferred in.
// Depends on ica_pkg, ica_ctrl, ica_dp and ica_ram.
module instruction_current_accumulator #(
    parameter int SLOT_COUNT = ica_pkg::SLOT_COUNT_DEF,
    parameter int TYPE_COUNT = ica_pkg::TYPE_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [31:0]                   cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [ica_pkg::TICK_W-1:0]    tick,
    input  logic [ica_pkg::ADDR_W-1:0]    fetch_address,
    input  logic [ica_pkg::TYPE_W-1:0]    instr_type,
    input  logic [ica_pkg::CYC_IN_W-1:0]  cycles,
    input  logic [ica_pkg::META_W-1:0]    access_meta,
    input  logic [ica_pkg::ADDR_W-1:0]    base_reg_value,
    input  logic [ica_pkg::ADDR_W-1:0]    index_reg_value,
    input  logic [ica_pkg::QUERY_W-1:0]   query_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ica_pkg::SLOTNUM_W-1:0] slot_number,
    output logic [ica_pkg::CHARGE_W-1:0]  slot_charge_total,
    output logic [ica_pkg::CYCLE_W-1:0]   slot_cycle_total,
    output logic [ica_pkg::USAGE_W-1:0]   usage_count,
    output logic                          slot_overflow
);
    import ica_pkg::*;

    ica_cmd_t cmd;
    ica_sts_t sts;

    ica_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ica_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .TYPE_COUNT (TYPE_COUNT)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .opcode            (opcode),
        .tick              (tick),
        .fetch_address     (fetch_address),
        .instr_type        (instr_type),
        .cycles            (cycles),
        .access_meta       (access_meta),
        .base_reg_value    (base_reg_value),
        .index_reg_value   (index_reg_value),
        .query_index       (query_index),
        .cmd               (cmd),
        .sts               (sts),
        .slot_number       (slot_number),
        .slot_charge_total (slot_charge_total),
        .slot_cycle_total  (slot_cycle_total),
        .usage_count       (usage_count),
        .slot_overflow     (slot_overflow)
    );

endmodule

### verif/tb.sv
// Testbench of instruction_current_accumulator: directed and random charge, read and
// branch sequences checked against an in-bench predictor through a scoreboard class.
// Depends on ica_pkg and the accumulator RTL.
`timescale 1ns / 100ps

module tb;
    import ica_pkg::*;

    localparam int NSLOT = 1024;
    localparam int NTYPE = 64;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] tck;
        logic [31:0] addr;
        logic [5:0]  itype;
        logic [3:0]  cyc;
        logic [15:0] meta;
        logic [31:0] base;
        logic [31:0] idx;
        logic [9:0]  query;
    } item_t;

    typedef struct packed {
        logic [9:0]  slot;
        logic [63:0] charge;
        logic [31:0] ccount;
        logic [31:0] usage;
        logic        ovf;
    } result_t;

    class charge_scoreboard;
        logic [63:0] charge_mem [NSLOT];
        logic [31:0] cycle_mem [NSLOT];
        logic [31:0] usage_mem [NTYPE];
        logic [31:0] slot_len;
        logic [31:0] prev_addr;
        logic        br_pend;
        logic [31:0] cur_slot;
        logic        cur_ok;
        logic [31:0] taken_chg;
        logic [31:0] nt_chg;
        logic [31:0] nt_cyc;
        result_t     expq [$];
        int          errors;

        function new();
            for (int i = 0; i < NSLOT; i++) begin
                charge_mem[i] = '0;
                cycle_mem[i] = '0;
            end
            for (int i = 0; i < NTYPE; i++) usage_mem[i] = '0;
            slot_len = 32'd1000;
            prev_addr = '0;
            br_pend = 1'b0;
            cur_slot = '0;
            cur_ok = 1'b1;
            taken_chg = '0;
            nt_chg = '0;
            nt_cyc = '0;
            errors = 0;
        endfunction

        function logic [31:0] flash_charge(logic [31:0] d);
            int msb;
            msb = -1;
            for (int b = 0; b < 32; b++) if (d[b]) msb = b;
            if (msb <= 3) return 32'd0;
            if (msb <= 5) return 32'd67;
            if (msb <= 7) return 32'd233;
            if (msb <= 9) return 32'd867;
            if (msb <= 11) return 32'd967;
            return 32'd1067;
        endfunction

        function logic [31:0] base_current(logic [5:0] t);
            case (t)
                6'd2: return 32'd4520;
                6'd3: return 32'd3827;
                6'd4: return 32'd3840;
                6'd5: return 32'd3933;
                6'd6, 6'd8, 6'd9, 6'd10: return 32'd3760;
                6'd7, 6'd30: return 32'd3867;
                6'd11, 6'd12, 6'd13: return 32'd3707;
                6'd14, 6'd15, 6'd16: return 32'd3693;
                6'd17: return 32'd3826;
                6'd23: return 32'd4867;
                6'd24: return 32'd4947;
                6'd25: return 32'd4773;
                6'd26, 6'd27: return 32'd4933;
                default: return 32'd4000;
            endcase
        endfunction

        function logic [31:0] current_of(item_t it);
            logic [31:0] step;
            logic [31:0] a;
            step = ({28'd0, it.cyc} - 32'd2) * 32'd240;
            if (it.itype == T_STR || it.itype == T_LDR) begin
                if (it.meta[14:11] == 4'hf) a = RAM_BASE - 32'd1;
                else if (it.meta[14:11] == 4'he) a = RAM_BASE;
                else if (it.meta[15]) a = it.base + it.idx;
                else a = it.base + {21'd0, it.meta[10:0]};
                if (it.itype == T_LDR) begin
                    if (a < RAM_BASE) return 32'd5760;
                    if (a < PERIPH_BASE) return 32'd3520;
                    return 32'd3000;
                end
                return (a >= PERIPH_BASE) ? 32'd3000 : 32'd4133;
            end
            if (it.itype == T_PUSH || it.itype == T_STMIA) return 32'd4133 - step;
            if (it.itype == T_LDMIA) return 32'd5760 - step;
            if (it.itype == T_POP) return 32'd3520 - step;
            return base_current(it.itype);
        endfunction

        function void note(item_t it);
            result_t r;
            logic [31:0] len, slot, fl, cur, c32;
            r = '0;
            if (it.op == OP_READ_SLOT) begin
                if (it.query < NSLOT) begin
                    r.slot = it.query;
                    r.charge = charge_mem[it.query];
                    r.ccount = cycle_mem[it.query];
                end else r.ovf = 1'b1;
            end else if (it.op == OP_READ_USAGE) begin
                if (it.query < NTYPE) r.usage = usage_mem[it.query];
            end else if (it.op == OP_CHARGE) begin
                c32 = {28'd0, it.cyc};
                fl = flash_charge(prev_addr ^ it.addr);
                if (br_pend) begin
                    br_pend = 1'b0;
                    if (cur_ok) begin
                        if (it.addr - prev_addr == 32'd2) begin
                            charge_mem[cur_slot] += {32'd0, nt_chg};
                            cycle_mem[cur_slot] += nt_cyc;
                        end else begin
                            charge_mem[cur_slot] += {32'd0, taken_chg};
                            cycle_mem[cur_slot] += 32'd3;
                        end
                    end
                end
                len = (slot_len == 0) ? 32'd1 : slot_len;
                slot = it.tck / len;
                cur_ok = slot < NSLOT;
                cur_slot = cur_ok ? slot : 32'd0;
                cur = current_of(it);
                if (it.itype == T_BNE || it.itype == T_BEQ || it.itype == T_BRANCH) begin
                    br_pend = 1'b1;
                    taken_chg = 32'd3 * cur + fl;
                    nt_cyc = c32;
                    nt_chg = c32 * ((it.itype == T_BNE) ? 32'd5200 : 32'd3920) + fl;
                end else if (cur_ok) begin
                    charge_mem[cur_slot] += {32'd0, c32 * cur + fl};
                    cycle_mem[cur_slot] += c32;
                end
                if (it.itype < NTYPE) usage_mem[it.itype] += 32'd1;
                prev_addr = it.addr;
                if (cur_ok) begin
                    r.slot = cur_slot[9:0];
                    r.charge = charge_mem[cur_slot];
                    r.ccount = cycle_mem[cur_slot];
                end else r.ovf = 1'b1;
            end
            expq.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(result_t got);
            result_t w;
            if (expq.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            w = expq.pop_front();
            if (got.slot !== w.slot)
                report($sformatf("slot_number %0d, want %0d", got.slot, w.slot));
            if (got.charge !== w.charge)
                report($sformatf("slot_charge_total %0d, want %0d", got.charge, w.charge));
            if (got.ccount !== w.ccount)
                report($sformatf("slot_cycle_total %0d, want %0d", got.ccount, w.ccount));
            if (got.usage !== w.usage)
                report($sformatf("usage_count %0d, want %0d", got.usage, w.usage));
            if (got.ovf !== w.ovf)
                report($sformatf("slot_overflow %0d, want %0d", got.ovf, w.ovf));
        endtask
    endclass

    logic        clk, rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        in_valid, in_stall, out_valid, out_stall;
    item_t       drv;
    logic [9:0]  slot_number;
    logic [63:0] slot_charge_total;
    logic [31:0] slot_cycle_total, usage_count;
    logic        slot_overflow;

    charge_scoreboard charge_sb;
    int          sent;
    bit          quiet;
    bit          hold_done;
    int          hold_left;
    logic [31:0] pc;
    logic [31:0] eff_len;
    logic [9:0]  hot_slot;

    instruction_current_accumulator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(drv.op), .tick(drv.tck), .fetch_address(drv.addr),
        .instr_type(drv.itype), .cycles(drv.cyc), .access_meta(drv.meta),
        .base_reg_value(drv.base), .index_reg_value(drv.idx), .query_index(drv.query),
        .out_valid(out_valid), .out_stall(out_stall),
        .slot_number(slot_number), .slot_charge_total(slot_charge_total),
        .slot_cycle_total(slot_cycle_total), .usage_count(usage_count),
        .slot_overflow(slot_overflow)
    );

    always #6 clk = ~clk;

    initial begin
        #(12 * 800000);
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                charge_sb.note(drv);
                sent++;
            end
            if (out_valid && !out_stall)
                charge_sb.check({slot_number, slot_charge_total, slot_cycle_total,
                                 usage_count, slot_overflow});
        end
    end

    // Receiver: random stalls, plus one long hold-off once traffic is flowing.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else if (!hold_done && sent >= 300) begin
                hold_done = 1'b1;
                hold_left = 400;
                out_stall = 1'b1;
            end else
                out_stall = !quiet && ($urandom_range(99) < 19);
        end
    end

    task automatic send(input item_t it);
        if (!quiet && $urandom_range(99) < 19) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        drv = it;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (charge_sb.expq.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic set_slot_length(input logic [31:0] v);
        drain();
        cfg_wr_en = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        charge_sb.slot_len = v;
        eff_len = (v == 0) ? 32'd1 : v;
        hot_slot = 10'($urandom_range(0, 1023));
    endtask

    function automatic logic [31:0] pick_tick();
        logic [63:0] t;
        int unsigned s;
        if ($urandom_range(99) < 12) return $urandom;
        if ($urandom_range(99) < 40) s = 32'(hot_slot);
        else if ($urandom_range(99) < 10) s = $urandom_range(1024, 1100);
        else s = $urandom_range(0, 1023);
        t = 64'(s) * 64'(eff_len) + 64'($urandom % eff_len);
        if (t[63:32] != 0) return $urandom;
        return t[31:0];
    endfunction

    function automatic logic [31:0] pick_base();
        case ($urandom_range(5))
            0: return RAM_BASE - $urandom_range(0, 3000);
            1: return RAM_BASE + $urandom_range(0, 16);
            2: return PERIPH_BASE - $urandom_range(0, 3000);
            3: return PERIPH_BASE + $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t charge_item(input logic [5:0] t, input bit follow);
        item_t it;
        it = '0;
        it.op = OP_CHARGE;
        it.tck = pick_tick();
        if (follow && $urandom_range(1)) pc = pc + 32'd2;
        else if ($urandom_range(99) < 70) pc = pc + 32'd2;
        else pc = pc ^ (32'd1 << $urandom_range(0, 31)) ^ ($urandom & 32'hf);
        it.addr = pc;
        it.itype = t;
        it.cyc = ($urandom_range(99) < 3) ? 4'd0 : 4'($urandom_range(1, 15));
        it.meta = 16'($urandom);
        it.base = pick_base();
        it.idx = ($urandom_range(1)) ? $urandom : $urandom_range(0, 4096);
        it.query = 10'($urandom);
        return it;
    endfunction

    function automatic item_t read_item(input logic [1:0] op);
        item_t it;
        it = '0;
        it.op = op;
        it.tck = $urandom;
        it.addr = $urandom;
        it.itype = 6'($urandom);
        it.cyc = 4'($urandom);
        it.meta = 16'($urandom);
        it.base = $urandom;
        it.idx = $urandom;
        if (op == OP_READ_USAGE)
            it.query = ($urandom_range(99) < 80) ? 10'($urandom_range(0, 63))
                                                 : 10'($urandom);
        else if ($urandom_range(99) < 50)
            it.query = hot_slot;
        else
            it.query = 10'($urandom);
        return it;
    endfunction

    task automatic random_run(input int n);
        item_t it;
        logic [5:0] t;
        bit after_branch;
        after_branch = 0;
        for (int i = 0; i < n; i++) begin
            quiet = (sent >= 700 && sent < 900);
            if (sent >= 1000 && sent < 1001 + n && i == n / 2)
                drain();
            case ($urandom_range(19))
                0, 1: it = read_item(OP_READ_SLOT);
                2: it = read_item(OP_READ_USAGE);
                3: it = read_item(OP_NONE);
                default: begin
                    if ($urandom_range(99) < 8) t = 6'($urandom);
                    else if ($urandom_range(99) < 30)
                        t = ($urandom_range(1)) ? T_BNE : (($urandom_range(1)) ? T_BEQ
                                                                            : T_BRANCH);
                    else t = 6'($urandom_range(0, 31));
                    it = charge_item(t, after_branch);
                    after_branch = (t == T_BNE || t == T_BEQ || t == T_BRANCH);
                end
            endcase
            send(it);
        end
    endtask

    initial begin
        item_t it;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        drv = '0;
        sent = 0;
        quiet = 0;
        hold_done = 0;
        hold_left = 0;
        pc = 32'h0000_0100;
        eff_len = 32'd1000;
        hot_slot = 10'd3;
        charge_sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: regions of loads and stores, multi-register forms, branches both ways.
        it = charge_item(T_STR, 0); it.meta = 16'h7800; it.tck = 32'd5; send(it);
        it = charge_item(T_STR, 0); it.meta = 16'h0000; it.base = PERIPH_BASE;
        it.tck = 32'd7; send(it);
        it = charge_item(T_LDR, 0); it.meta = 16'h7000; it.tck = 32'd9; send(it);
        it = charge_item(T_LDR, 0); it.meta = 16'h8000; it.base = RAM_BASE - 32'd4;
        it.idx = 32'd4; it.tck = 32'd999; send(it);
        it = charge_item(T_LDR, 0); it.meta = 16'h07ff; it.base = PERIPH_BASE - 32'h7ff;
        send(it);
        it = charge_item(T_PUSH, 0); it.cyc = 4'd1; send(it);
        it = charge_item(T_STMIA, 0); it.cyc = 4'd15; send(it);
        it = charge_item(T_LDMIA, 0); it.cyc = 4'd15; send(it);
        it = charge_item(T_POP, 0); it.cyc = 4'd0; send(it);
        it = charge_item(T_BNE, 0); it.tck = 32'd1000; send(it);
        pc = pc + 32'd2;
        it = charge_item(6'd4, 0); it.addr = pc; it.tck = 32'd1000; send(it);
        it = charge_item(T_BEQ, 0); it.tck = 32'd2000; send(it);
        pc = pc ^ 32'h8000_0000;
        it = charge_item(6'd63, 0); it.addr = pc; it.tck = 32'd2001; send(it);
        // Deferred branch whose slot lies beyond the store, so it is not charged.
        it = charge_item(T_BRANCH, 0); it.tck = 32'hffff_ffff; send(it);
        it = charge_item(6'd2, 0); it.tck = 32'd0; it.addr = 32'hffff_ffff; pc = it.addr;
        send(it);
        it = read_item(OP_READ_SLOT); it.query = 10'd0; send(it);
        it = read_item(OP_READ_SLOT); it.query = 10'd1; send(it);
        it = read_item(OP_READ_SLOT); it.query = 10'd1023; send(it);
        it = read_item(OP_READ_USAGE); it.query = 10'(T_LDR); send(it);
        it = read_item(OP_READ_USAGE); it.query = 10'd63; send(it);
        it = read_item(OP_READ_USAGE); it.query = 10'd1023; send(it);
        it = read_item(OP_NONE); it = '1; send(it);

        random_run(300);
        set_slot_length(32'd1);
        random_run(200);
        set_slot_length(32'd0);
        random_run(150);
        set_slot_length(32'hffff_ffff);
        random_run(150);
        set_slot_length($urandom_range(2, 5000));
        random_run(300);
        set_slot_length($urandom | 32'h0010_0000);
        random_run(150);
        set_slot_length(32'd1000);
        random_run(150);

        drain();
        if (charge_sb.errors == 0 && charge_sb.expq.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
